[src/assert_macros.svh]
// Assertion macros shared by the span buffer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define SSB_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("ssb check failed");
// Check a property on every clock edge, reset included
`define SSB_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("ssb check failed");
`else
`define SSB_ASSERT(lbl, clk, rst, prop)
`define SSB_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[src/ssb_pkg.sv]
// Types and constants shared by the scanline span buffer
`timescale 1ns / 1ps
package ssb_pkg;

  localparam int MAX_LINES_DEF      = 1024;
  localparam int SPANS_PER_LINE_DEF = 8;
  localparam int COORD_BITS_DEF     = 10;

  localparam int IN_W      = 11;
  localparam int ID_W      = 15;
  localparam int FOUND_W   = 16;
  localparam int REG_W     = 11;
  localparam int FRAC_BITS = 16;

  localparam logic [REG_W-1:0]          REG_RESET  = 11'd1024;
  localparam logic signed [FOUND_W-1:0] FOUND_NONE = -16'sd1;

  typedef enum logic [1:0] {
    MODE_DRAW  = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_DROP  = 2'd2
  } status_t;

  typedef enum logic {
    REG_LINE_WIDTH = 1'b0,
    REG_LINE_COUNT = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    HOW_BOTH  = 2'd0,
    HOW_LEFT  = 2'd1,
    HOW_RIGHT = 2'd2
  } how_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_H_RD,
    S_H_MOD,
    S_DIV_GO,
    S_DIV,
    S_WALK,
    S_Q_RD,
    S_Q_CNT,
    S_Q_SCAN,
    S_FIN
  } state_t;

endpackage

[src/scanline_span_buffer.sv]
// Scanline span buffer: per-line span lists for polygon edges, point queries and clear.
// Each item gives one result beat. A query scans the spans of its line, one span a cycle,
// through the span memory read port. A horizontal draw reads and rewrites its line, and an
// out-of-range draw returns ST_RANGE without touching memory. A sloped edge runs the
// bit-serial slope divider, then walks the scanlines it crosses: the walk reads the
// line memory for the next line while it writes back the current one. A clear sweeps the
// line memory one line a cycle; the same pass runs after reset, during which no item is
// accepted (configuration writes are taken at any time).
`timescale 1ns / 1ps
`include "assert_macros.svh"
module scanline_span_buffer #(
  parameter int MAX_LINES      = ssb_pkg::MAX_LINES_DEF,
  parameter int SPANS_PER_LINE = ssb_pkg::SPANS_PER_LINE_DEF,
  parameter int COORD_BITS     = ssb_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic                               cfg_index,
  input  logic [ssb_pkg::REG_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         mode,
  input  logic signed [ssb_pkg::IN_W-1:0]    x0,
  input  logic signed [ssb_pkg::IN_W-1:0]    y0,
  input  logic signed [ssb_pkg::IN_W-1:0]    x1,
  input  logic signed [ssb_pkg::IN_W-1:0]    y1,
  input  logic signed [ssb_pkg::IN_W-1:0]    offset_x,
  input  logic signed [ssb_pkg::IN_W-1:0]    offset_y,
  input  logic [ssb_pkg::ID_W-1:0]           shape_id,
  input  logic                               edge_last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [ssb_pkg::FOUND_W-1:0] found_id,
  output logic [1:0]                         status
);

  import ssb_pkg::*;

  localparam int CB         = COORD_BITS;
  localparam int LW         = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int SIW        = (SPANS_PER_LINE > 1) ? $clog2(SPANS_PER_LINE) : 1;
  localparam int NW         = $clog2(SPANS_PER_LINE + 1);
  localparam int SPAN_W     = 2 * CB + ID_W;
  localparam int LINE_E_W   = NW + SPAN_W;
  localparam int SPAN_DEPTH = 1 << (LW + SIW);
  localparam int WW         = (CB + 1 > IN_W + 1) ? CB + 1 : IN_W + 1;
  localparam int HW         = (LW + 1 > IN_W + 1) ? LW + 1 : IN_W + 1;
  localparam int DIVN_W     = CB + FRAC_BITS;
  localparam int ACC_W      = CB + FRAC_BITS + 2;
  localparam int XV_W       = ACC_W - FRAC_BITS;
  localparam int CMP_W      = WW + 2;
  localparam int W_LIM      = 1 << CB;
  localparam int H_LIM      = MAX_LINES;

  // configuration
  logic [REG_W-1:0] line_width;
  logic [REG_W-1:0] line_count;
  logic [WW-1:0]    w_eff;
  logic [WW-1:0]    w_max;
  logic [HW-1:0]    h_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= REG_RESET;
      line_count <= REG_RESET;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LINE_WIDTH: line_width <= cfg_data;
        REG_LINE_COUNT: line_count <= cfg_data;
      endcase
    end
  end

  assign w_eff = (WW'(line_width) < WW'(W_LIM)) ? WW'(line_width) : WW'(W_LIM);
  assign w_max = w_eff - WW'(1);
  assign h_eff = (HW'(line_count) < HW'(H_LIM)) ? HW'(line_count) : HW'(H_LIM);

  // input decode
  logic signed [IN_W:0] sx0, sy0, sx1, sy1;
  logic signed [WW-1:0] ex0, ex1, eqx;
  logic signed [HW-1:0] ey0, ey1, eqy;
  logic                 draw_ok, query_ok;
  logic [CB-1:0]        cx0, cx1;
  logic [LW-1:0]        cy0, cy1;

  assign sx0 = (IN_W + 1)'(x0) + (IN_W + 1)'(offset_x);
  assign sx1 = (IN_W + 1)'(x1) + (IN_W + 1)'(offset_x);
  assign sy0 = (IN_W + 1)'(y0) + (IN_W + 1)'(offset_y);
  assign sy1 = (IN_W + 1)'(y1) + (IN_W + 1)'(offset_y);
  assign ex0 = WW'(sx0);
  assign ex1 = WW'(sx1);
  assign ey0 = HW'(sy0);
  assign ey1 = HW'(sy1);
  assign eqx = WW'(x0);
  assign eqy = HW'(y0);

  assign draw_ok = !ex0[WW-1] && ($unsigned(ex0) < w_eff) &&
                   !ex1[WW-1] && ($unsigned(ex1) < w_eff) &&
                   !ey0[HW-1] && ($unsigned(ey0) < h_eff) &&
                   !ey1[HW-1] && ($unsigned(ey1) < h_eff);
  assign query_ok = !eqx[WW-1] && ($unsigned(eqx) < w_eff) &&
                    !eqy[HW-1] && ($unsigned(eqy) < h_eff);

  assign cx0 = ex0[CB-1:0];
  assign cx1 = ex1[CB-1:0];
  assign cy0 = ey0[LW-1:0];
  assign cy1 = ey1[LW-1:0];

  // state and item registers
  state_t state, state_next;

  logic [CB-1:0]              xa, xb, qx;
  logic [LW-1:0]              ya, yb;
  logic [ID_W-1:0]            owner;
  how_t                       how;
  logic                       neg;
  logic signed [ACC_W-1:0]    acc, dx;
  logic [LW-1:0]              y_iss, p_y, clr_idx;
  logic [CB-1:0]              p_x;
  logic                       iss_done, p_valid, clr_resp;
  logic [SIW-1:0]             q_k;
  logic signed [FOUND_W-1:0]  res_found;
  status_t                    res_status;

  // memories
  logic                  line_we;
  logic [LW-1:0]         line_waddr, line_raddr;
  logic [LINE_E_W-1:0]   line_wdata, line_rdata;
  logic                  span_we;
  logic [LW+SIW-1:0]     span_waddr, span_raddr;
  logic [SPAN_W-1:0]     span_wdata, span_rdata;

  // line entry holds the span count and a copy of the newest span
  ssb_ram #(.WIDTH(LINE_E_W), .DEPTH(MAX_LINES)) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (line_wdata),
    .raddr (line_raddr),
    .rdata (line_rdata)
  );

  ssb_ram #(.WIDTH(SPAN_W), .DEPTH(SPAN_DEPTH)) u_span_ram (
    .clk   (clk),
    .we    (span_we),
    .waddr (span_waddr),
    .wdata (span_wdata),
    .raddr (span_raddr),
    .rdata (span_rdata)
  );

  // slope divider
  logic              div_start, div_done;
  logic [DIVN_W-1:0] div_num, div_quot;
  logic [LW-1:0]     div_den;
  logic [CB-1:0]     xdiff;

  assign xdiff     = (xb >= xa) ? (xb - xa) : (xa - xb);
  assign div_num   = {xdiff, {FRAC_BITS{1'b0}}};
  assign div_den   = yb - ya;
  assign div_start = (state == S_DIV_GO);

  ssb_div #(.NUM_W(DIVN_W), .DEN_W(LW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // edge walk: x for the line being issued
  logic signed [XV_W-1:0]  xv;
  logic signed [CMP_W-1:0] xv_cmp, w_cmp;
  logic [CB-1:0]           x_clamp, x_issue;
  logic                    iss_en;

  assign xv      = acc[ACC_W-1:FRAC_BITS];
  assign xv_cmp  = CMP_W'(xv);
  assign w_cmp   = signed'(CMP_W'(w_eff));
  assign x_clamp = xv[XV_W-1] ? '0 : ((xv_cmp >= w_cmp) ? w_max[CB-1:0] : xv[CB-1:0]);
  assign x_issue = (y_iss == yb) ? xb : x_clamp;
  assign iss_en  = (state == S_WALK) && !iss_done;

  // span update: widen or move an end of the newest span, else append, or drop if the line is full
  logic [NW-1:0]   le_n;
  logic [CB-1:0]   le_l, le_r;
  logic [ID_W-1:0] le_o;
  logic            ps_en, ps_match, ps_drop;
  logic [LW-1:0]   ps_y;
  logic [CB-1:0]   ps_xl, ps_xr, new_l, new_r;
  logic [SIW-1:0]  ps_k;

  assign le_n = line_rdata[LINE_E_W-1 -: NW];
  assign le_l = line_rdata[SPAN_W-1 -: CB];
  assign le_r = line_rdata[SPAN_W-CB-1 -: CB];
  assign le_o = line_rdata[ID_W-1:0];

  assign ps_en    = (state == S_H_MOD) || ((state == S_WALK) && p_valid);
  assign ps_y     = (state == S_H_MOD) ? ya : p_y;
  assign ps_xl    = (state == S_H_MOD) ? xa : p_x;
  assign ps_xr    = (state == S_H_MOD) ? xb : p_x;
  assign ps_match = (le_n != '0) && (le_o == owner);
  assign ps_drop  = !ps_match && (le_n >= NW'(SPANS_PER_LINE));
  assign ps_k     = ps_match ? SIW'(le_n - NW'(1)) : SIW'(le_n);

  always_comb begin
    new_l = ps_xl;
    new_r = ps_xr;
    if (ps_match) begin
      unique case (how)
        HOW_BOTH: begin
          new_l = (le_l > ps_xl) ? ps_xl : le_l;
          new_r = (le_r < ps_xr) ? ps_xr : le_r;
        end
        HOW_LEFT: begin
          new_l = ps_xl;
          new_r = le_r;
        end
        HOW_RIGHT: begin
          new_l = le_l;
          new_r = ps_xr;
        end
        default: begin
          new_l = le_l;
          new_r = le_r;
        end
      endcase
    end
  end

  // query scan
  logic [CB-1:0]   sp_l, sp_r;
  logic [ID_W-1:0] sp_o;
  logic            q_cover;

  assign sp_l    = span_rdata[SPAN_W-1 -: CB];
  assign sp_r    = span_rdata[SPAN_W-CB-1 -: CB];
  assign sp_o    = span_rdata[ID_W-1:0];
  assign q_cover = (sp_l <= qx) && (sp_r >= qx);

  // memory ports
  always_comb begin
    line_we    = 1'b0;
    line_waddr = ps_y;
    line_wdata = {le_n + NW'(1), new_l, new_r, owner};
    span_we    = ps_en && !ps_drop;
    span_waddr = {ps_y, ps_k};
    span_wdata = {new_l, new_r, owner};
    if (state == S_CLEAR) begin
      line_we    = 1'b1;
      line_waddr = clr_idx;
      line_wdata = '0;
    end else if (ps_en && !ps_drop) begin
      line_we = 1'b1;
      if (ps_match) begin
        line_wdata = {le_n, new_l, new_r, owner};
      end
    end
    line_raddr = (state == S_WALK) ? y_iss : ya;
    if (state == S_Q_CNT) begin
      span_raddr = {ya, SIW'(le_n - NW'(1))};
    end else begin
      span_raddr = {ya, q_k - SIW'(1)};
    end
  end

  // state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          priority if (mode_t'(mode) == MODE_DRAW) begin
            if (!draw_ok) begin
              state_next = S_FIN;
            end else if (ey0 == ey1) begin
              state_next = S_H_RD;
            end else begin
              state_next = S_DIV_GO;
            end
          end else if (mode_t'(mode) == MODE_QUERY) begin
            state_next = query_ok ? S_Q_RD : S_FIN;
          end else if (mode_t'(mode) == MODE_CLEAR) begin
            state_next = S_CLEAR;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_CLEAR: begin
        if (clr_idx == LW'(MAX_LINES - 1)) begin
          state_next = clr_resp ? S_FIN : S_IDLE;
        end
      end
      S_H_RD:   state_next = S_H_MOD;
      S_H_MOD:  state_next = S_FIN;
      S_DIV_GO: state_next = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (iss_done && !p_valid) begin
          state_next = S_FIN;
        end
      end
      S_Q_RD:  state_next = S_Q_CNT;
      S_Q_CNT: state_next = (le_n == '0) ? S_FIN : S_Q_SCAN;
      S_Q_SCAN: begin
        if (q_cover || (q_k == '0)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx  <= '0;
      clr_resp <= 1'b0;
      p_valid  <= 1'b0;
      iss_done <= 1'b1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            res_found  <= FOUND_NONE;
            res_status <= ST_OK;
            owner      <= shape_id;
            how        <= HOW_BOTH;
            clr_idx    <= '0;
            clr_resp   <= 1'b1;
            priority if (mode_t'(mode) == MODE_DRAW) begin
              if (!draw_ok) begin
                res_status <= ST_RANGE;
              end else if (ey0 == ey1) begin
                xa <= (cx0 < cx1) ? cx0 : cx1;
                xb <= (cx0 < cx1) ? cx1 : cx0;
                ya <= cy0;
              end else if (ey1 < ey0) begin
                // upward edge: walk from the lower y, set left ends
                how <= HOW_LEFT;
                xa  <= cx1;
                ya  <= cy1;
                xb  <= cx0;
                yb  <= cy0;
              end else begin
                how <= HOW_RIGHT;
                xa  <= cx0;
                ya  <= cy0;
                xb  <= cx1;
                yb  <= cy1;
              end
            end else if (mode_t'(mode) == MODE_QUERY) begin
              if (!query_ok) begin
                res_status <= ST_RANGE;
              end else begin
                qx <= eqx[CB-1:0];
                ya <= eqy[LW-1:0];
              end
            end else begin
              res_status <= ST_OK;
            end
          end
        end
        S_CLEAR: begin
          clr_idx <= clr_idx + LW'(1);
        end
        S_DIV_GO: begin
          neg <= (xb < xa);
        end
        S_DIV: begin
          if (div_done) begin
            dx       <= neg ? -$signed(ACC_W'(div_quot)) : $signed(ACC_W'(div_quot));
            acc      <= signed'(ACC_W'({xa, {FRAC_BITS{1'b0}}}));
            y_iss    <= ya;
            iss_done <= 1'b0;
            p_valid  <= 1'b0;
          end
        end
        S_WALK: begin
          // issue the read for the next line while the current one is written back
          p_valid <= iss_en;
          if (iss_en) begin
            p_y   <= y_iss;
            p_x   <= x_issue;
            acc   <= acc + dx;
            y_iss <= y_iss + LW'(1);
            if (y_iss == yb) begin
              iss_done <= 1'b1;
            end
          end
        end
        S_Q_CNT: begin
          q_k <= SIW'(le_n - NW'(1));
        end
        S_Q_SCAN: begin
          if (q_cover) begin
            res_found <= {1'b0, sp_o};
          end else begin
            q_k <= q_k - SIW'(1);
          end
        end
        default: ;
      endcase
      if (ps_en && ps_drop) begin
        res_status <= ST_DROP;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_FIN) && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
      found_id  <= res_found;
      status    <= res_status;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `SSB_ASSERT(a_walk_lines_apart, clk, rst, (p_valid && iss_en) |-> (p_y != y_iss))
  `SSB_ASSERT(a_div_done_in_div, clk, rst, div_done |-> (state == S_DIV))
  `SSB_ASSERT(a_clear_exits, clk, rst, (state == S_CLEAR) |=> (state == S_CLEAR || state == S_IDLE || state == S_FIN))
  `SSB_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> (state == S_CLEAR))

endmodule

[src/ssb_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read
`timescale 1ns / 1ps
module ssb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/ssb_div.sv]
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module ssb_div #(
  parameter int NUM_W = 26,
  parameter int DEN_W = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem, quot[NUM_W-1]};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quot <= num;
        rem  <= '0;
        dvs  <= den;
        cnt  <= CNT_W'(NUM_W);
        busy <= 1'b1;
      end else if (busy) begin
        // shift in one dividend bit, subtract where the divisor fits
        rem  <= fits ? DEN_W'(trial - {1'b0, dvs}) : trial[DEN_W-1:0];
        quot <= {quot[NUM_W-2:0], fits};
        cnt  <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
